// ===== hw/rtl/smoe_pkg.sv =====
// Shared types and constants for the small matrix engine.
`timescale 1ns / 1ps
package smoe_pkg;
   localparam int MAX_DIM = 8;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = $clog2(DEPTH);
   localparam int IW = $clog2(MAX_DIM);
   localparam int QDEPTH = 4;

   localparam logic [1:0] ACT_LOAD_A = 2'd0;
   localparam logic [1:0] ACT_LOAD_B = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_TRN = 3'd3;
   localparam logic [2:0] OP_SYM = 3'd4;
   localparam logic [2:0] OP_DIAG = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DIM = 2'd1;
   localparam logic [1:0] ST_SQUARE = 2'd2;

   localparam logic [2:0] REG_OP = 3'd0;
   localparam logic [2:0] REG_RA = 3'd1;
   localparam logic [2:0] REG_CA = 3'd2;
   localparam logic [2:0] REG_RB = 3'd3;
   localparam logic [2:0] REG_CB = 3'd4;

   // compute job handed from front to back
   typedef struct packed {
      logic [2:0] op;
      logic [3:0] ra;
      logic [3:0] ca;
      logic [3:0] rb;
      logic [3:0] cb;
   } job_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RUN, S_WAIT, S_ACC, S_EMIT
   } back_state_type;

   function automatic logic [3:0] eff_dim(input logic [3:0] d);
      if (d == 4'd0) return 4'd1;
      if (d > 4'(MAX_DIM)) return 4'(MAX_DIM);
      return d;
   endfunction
endpackage

// ===== hw/rtl/smoe_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface smoe_req_if;
   logic valid;
   logic ready;
   logic [1:0] action;
   logic signed [31:0] element;
   modport source (output valid, action, element, input ready);
   modport sink (input valid, action, element, output ready);
endinterface

interface smoe_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] result_value;
   logic [2:0] result_row;
   logic [2:0] result_col;
   logic [1:0] status;
   logic last;
   modport source (output valid, result_value, result_row, result_col, status, last,
                   input ready);
   modport sink (input valid, result_value, result_row, result_col, status, last,
                 output ready);
endinterface

// ===== hw/rtl/small_matrix_operation_engine.sv =====
// Top level: a load is written straight into its store; a compute request is queued and
// run by the back end, and no request is taken while a compute is queued or running.
// Symmetry scans all rows_a*rows_a pairs and reports once. A stalled result output
// holds the back end until the result is taken. Reset: synchronous, active high;
// clears the stores (valid bits), load pointers, queue, configuration and sequencer
// state.
`timescale 1ns / 1ps
module small_matrix_operation_engine (
   input  logic clock,
   input  logic reset,
   smoe_req_if.sink req,
   smoe_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import smoe_pkg::*;
   job_type cfg, job;
   logic wr_a, wr_b, job_valid, job_take, back_busy;
   logic [AW-1:0] wr_addr;
   logic [31:0] wr_data, val;

   smoe_csr u_csr (.clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
                   .csr_pwdata, .csr_prdata, .csr_pready, .cfg);

   smoe_front u_front (.clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
                       .req_action(req.action), .req_element(req.element), .cfg,
                       .wr_a, .wr_b, .wr_addr, .wr_data, .job_valid, .job, .job_take,
                       .back_busy);

   smoe_back u_back (.clock, .reset, .wr_a, .wr_b, .wr_addr, .wr_data, .job_valid,
                     .job, .job_take, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
                     .rsp_result_value(val), .rsp_result_row(rsp.result_row),
                     .rsp_result_col(rsp.result_col), .rsp_status(rsp.status),
                     .rsp_last(rsp.last), .busy(back_busy));
   assign rsp.result_value = val;
endmodule

// ===== hw/rtl/smoe_front.sv =====
// Front end: classifies requests, writes loads, queues compute jobs.
`timescale 1ns / 1ps
module smoe_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_action,
   input  logic [31:0] req_element,
   input  smoe_pkg::job_type cfg,
   output logic wr_a,
   output logic wr_b,
   output logic [smoe_pkg::AW-1:0] wr_addr,
   output logic [31:0] wr_data,
   output logic job_valid,
   output smoe_pkg::job_type job,
   input  logic job_take,
   input  logic back_busy
);
   import smoe_pkg::*;
   localparam int QW = $clog2(QDEPTH);
   logic [AW:0] ptr_a_ff, ptr_a_in, ptr_b_ff, ptr_b_in;
   job_type q_ff [QDEPTH];
   logic [QW-1:0] rd_ff, wr_ff;
   logic [QW:0] cnt_ff;
   logic [7:0] size_a, size_b;
   logic acc, push, full;

   assign full = (cnt_ff == (QW+1)'(QDEPTH));
   // one compute at a time: hold requests while a compute is queued or running
   assign req_ready = !full && (cnt_ff == '0) && !back_busy;
   assign acc = req_valid && req_ready;
   assign size_a = 8'(eff_dim(cfg.ra)) * 8'(eff_dim(cfg.ca));
   assign size_b = 8'(eff_dim(cfg.rb)) * 8'(eff_dim(cfg.cb));
   assign push = acc && req_action == ACT_COMPUTE;

   // load writes and pointer update
   always_comb begin
      ptr_a_in = ptr_a_ff;
      ptr_b_in = ptr_b_ff;
      wr_a = 1'b0;
      wr_b = 1'b0;
      wr_addr = ptr_a_ff[AW-1:0];
      if (acc && req_action == ACT_LOAD_A && 8'(ptr_a_ff) < size_a) begin
         wr_a = 1'b1;
         ptr_a_in = ptr_a_ff + 1'b1;
      end
      if (acc && req_action == ACT_LOAD_B && 8'(ptr_b_ff) < size_b) begin
         wr_b = 1'b1;
         wr_addr = ptr_b_ff[AW-1:0];
         ptr_b_in = ptr_b_ff + 1'b1;
      end
      if (push) begin
         ptr_a_in = '0;
         ptr_b_in = '0;
      end
   end
   assign wr_data = req_element;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_a_ff <= '0;
         ptr_b_ff <= '0;
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         ptr_a_ff <= ptr_a_in;
         ptr_b_ff <= ptr_b_in;
         if (push) wr_ff <= wr_ff + 1'b1;
         if (job_take) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QW+1)'(push) - (QW+1)'(job_take);
      end
   end

   // job queue
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= cfg;
   end
   assign job_valid = (cnt_ff != '0);
   assign job = q_ff[rd_ff];
endmodule

// ===== hw/rtl/smoe_back.sv =====
// Back end: matrix stores and the sequencer that runs each operation.
`timescale 1ns / 1ps
module smoe_back (
   input  logic clock,
   input  logic reset,
   input  logic wr_a,
   input  logic wr_b,
   input  logic [smoe_pkg::AW-1:0] wr_addr,
   input  logic [31:0] wr_data,
   input  logic job_valid,
   input  smoe_pkg::job_type job,
   output logic job_take,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [31:0] rsp_result_value,
   output logic [2:0] rsp_result_row,
   output logic [2:0] rsp_result_col,
   output logic [1:0] rsp_status,
   output logic rsp_last,
   output logic busy
);
   import smoe_pkg::*;
   // stores: one write port each; A has a second read port for the symmetry scan;
   // valid bits make unwritten entries read as zero after reset
   logic [31:0] mem_a [DEPTH];
   logic [31:0] mem_b [DEPTH];
   logic [DEPTH-1:0] va_ff, vb_ff;
   logic [31:0] ra_data_ff, rb_data_ff;
   logic rva_ff, rvb_ff;
   logic [AW-1:0] addr_a, addr_b;

   back_state_type st_ff, st_in;
   job_type j_ff;
   logic [3:0] ra, ca, rb, cb;
   logic [IW:0] i_ff, i_in, jx_ff, jx_in, k_ff, k_in;
   logic [31:0] acc_ff, acc_in;
   logic sym_ff, sym_in;
   logic step_last, inner_last, issue, rsp_load;
   logic [31:0] a_q, b_q, val_in;
   logic [2:0] row_in, col_in;
   logic [1:0] stat_in;
   logic last_in;
   logic [IW:0] outer_n, inner_n;

   // row-major flat address
   function automatic logic [AW-1:0] flat_index(input logic [IW:0] r, input logic [3:0] n,
                                                 input logic [IW:0] c);
      return AW'(r) * AW'(n) + AW'(c);
   endfunction

   always_ff @(posedge clock) begin
      if (wr_a) mem_a[wr_addr] <= wr_data;
      if (wr_b) mem_b[wr_addr] <= wr_data;
      ra_data_ff <= mem_a[addr_a];
      rb_data_ff <= (j_ff.op == OP_SYM) ? mem_a[addr_b] : mem_b[addr_b];
      rva_ff <= va_ff[addr_a];
      rvb_ff <= (j_ff.op == OP_SYM) ? va_ff[addr_b] : vb_ff[addr_b];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
         vb_ff <= '0;
      end else begin
         if (wr_a) va_ff[wr_addr] <= 1'b1;
         if (wr_b) vb_ff[wr_addr] <= 1'b1;
      end
   end
   assign a_q = rva_ff ? ra_data_ff : '0;
   assign b_q = rvb_ff ? rb_data_ff : '0;

   assign ra = eff_dim(j_ff.ra);
   assign ca = eff_dim(j_ff.ca);
   assign rb = eff_dim(j_ff.rb);
   assign cb = eff_dim(j_ff.cb);
   assign busy = (st_ff != S_IDLE);

   // loop bounds per operation: i outer, jx middle, k inner (multiply only)
   always_comb begin
      outer_n = (IW+1)'(ra);
      inner_n = (IW+1)'(ca);
      unique case (j_ff.op)
         OP_MUL: inner_n = (IW+1)'(cb);
         OP_TRN: begin
            outer_n = (IW+1)'(ca);
            inner_n = (IW+1)'(ra);
         end
         OP_DIAG: inner_n = (IW+1)'(1);
         default: ;
      endcase
   end

   // store read addresses
   always_comb begin
      addr_a = flat_index(i_ff, ca, jx_ff);
      addr_b = flat_index(i_ff, cb, jx_ff);
      unique case (j_ff.op)
         OP_MUL: begin
            addr_a = flat_index(i_ff, ca, k_ff);
            addr_b = flat_index(k_ff, cb, jx_ff);
         end
         OP_TRN: addr_a = flat_index(jx_ff, ca, i_ff);
         OP_SYM: begin
            addr_a = flat_index(i_ff, ca, jx_ff);
            addr_b = flat_index(jx_ff, ca, i_ff);
         end
         OP_DIAG: addr_a = flat_index(i_ff, ca, i_ff);
         default: ;
      endcase
   end

   assign inner_last = (j_ff.op != OP_MUL) || (k_ff + 1'b1 == (IW+1)'(ca));
   assign step_last = inner_last && (jx_ff + 1'b1 == inner_n)
                      && (i_ff + 1'b1 == outer_n);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (job_valid) st_in = S_RUN;
         S_RUN: begin
            if (j_ff.op > OP_DIAG) st_in = S_IDLE;
            else if (((j_ff.op == OP_ADD || j_ff.op == OP_SUB) && (ra != rb || ca != cb))
                     || (j_ff.op == OP_MUL && ca != rb)
                     || ((j_ff.op == OP_SYM || j_ff.op == OP_DIAG) && ra != ca))
               st_in = S_EMIT;
            else st_in = S_WAIT;
         end
         S_WAIT: st_in = (j_ff.op == OP_MUL) ? S_ACC : S_EMIT;
         S_ACC: if (inner_last) st_in = S_EMIT;
         else st_in = S_WAIT;
         S_EMIT: if (rsp_load) st_in = (step_last || err_ff) ? S_IDLE : S_WAIT;
         default: st_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      job_take = (st_ff == S_IDLE) && job_valid;
      i_in = i_ff;
      jx_in = jx_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      sym_in = sym_ff;
      issue = 1'b0;
      val_in = acc_ff;
      row_in = i_ff[2:0];
      col_in = jx_ff[2:0];
      stat_in = ST_OK;
      last_in = step_last;
      if (j_ff.op == OP_ADD) val_in = a_q + b_q;
      else if (j_ff.op == OP_SUB) val_in = a_q - b_q;
      else if (j_ff.op == OP_TRN || j_ff.op == OP_DIAG) val_in = a_q;
      if (j_ff.op == OP_DIAG) col_in = i_ff[2:0];
      if (j_ff.op == OP_SYM) begin
         val_in = {31'd0, sym_ff && (a_q == b_q)};
         row_in = '0;
         col_in = '0;
         last_in = step_last;
      end
      if (st_ff == S_IDLE) begin
         i_in = '0;
         jx_in = '0;
         k_in = '0;
         acc_in = '0;
         sym_in = 1'b1;
      end
      if (st_ff == S_ACC) begin
         acc_in = acc_ff + a_q * b_q;
         if (!inner_last) k_in = k_ff + 1'b1;
      end
      if (st_ff == S_RUN && (st_in == S_EMIT)) begin
         issue = 1'b1;
         val_in = '0;
         row_in = '0;
         col_in = '0;
         stat_in = (j_ff.op == OP_ADD || j_ff.op == OP_SUB || j_ff.op == OP_MUL)
                   ? ST_DIM : ST_SQUARE;
         last_in = 1'b1;
      end
      if (st_ff == S_EMIT && j_ff.op == OP_SYM) sym_in = sym_ff && (a_q == b_q);
      // symmetry scan walks all pairs silently and reports once at the end
      rsp_load = (st_ff == S_EMIT) && (!rsp_valid || rsp_ready)
                 && (err_ff || j_ff.op != OP_SYM || step_last);
      if (st_ff == S_EMIT && (rsp_load || (j_ff.op == OP_SYM && !step_last))) begin
         k_in = '0;
         acc_in = '0;
         if (jx_ff + 1'b1 == inner_n) begin
            jx_in = '0;
            i_in = i_ff + 1'b1;
         end else jx_in = jx_ff + 1'b1;
      end
   end

   logic sym_adv;
   assign sym_adv = (st_ff == S_EMIT) && (j_ff.op == OP_SYM) && !step_last && !err_ff;
   logic err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rsp_valid <= 1'b0;
         err_ff <= 1'b0;
      end else begin
         if (sym_adv) st_ff <= S_WAIT;
         else if (st_ff == S_RUN && st_in == S_EMIT) st_ff <= S_EMIT;
         else st_ff <= st_in;
         if (st_ff == S_RUN) err_ff <= (st_in == S_EMIT);
         if (rsp_load || (st_ff == S_EMIT && err_ff && (!rsp_valid || rsp_ready)))
            rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) j_ff <= '0;
      else if (job_take) j_ff <= job;
      i_ff <= i_in;
      jx_ff <= jx_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      sym_ff <= sym_in;
   end

   // error result is captured in RUN, emitted from EMIT
   logic [31:0] e_val_ff;
   logic [2:0] e_row_ff, e_col_ff;
   logic [1:0] e_st_ff;
   logic e_last_ff;
   always_ff @(posedge clock) begin
      if (issue) begin
         e_val_ff <= val_in;
         e_row_ff <= row_in;
         e_col_ff <= col_in;
         e_st_ff <= stat_in;
         e_last_ff <= last_in;
      end
      if (st_ff == S_EMIT && err_ff && (!rsp_valid || rsp_ready)) begin
         rsp_result_value <= e_val_ff;
         rsp_result_row <= e_row_ff;
         rsp_result_col <= e_col_ff;
         rsp_status <= e_st_ff;
         rsp_last <= e_last_ff;
      end else if (rsp_load && !err_ff) begin
         rsp_result_value <= val_in;
         rsp_result_row <= row_in;
         rsp_result_col <= col_in;
         rsp_status <= stat_in;
         rsp_last <= last_in;
      end
   end
endmodule

// ===== hw/rtl/smoe_csr.sv =====
// APB-style configuration registers.
`timescale 1ns / 1ps
module smoe_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   output smoe_pkg::job_type cfg
);
   import smoe_pkg::*;
   job_type cfg_ff;
   logic [2:0] idx;
   assign idx = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{op: OP_ADD, ra: 4'd1, ca: 4'd1, rb: 4'd1, cb: 4'd1};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_OP: cfg_ff.op <= csr_pwdata[2:0];
            REG_RA: cfg_ff.ra <= csr_pwdata[3:0];
            REG_CA: cfg_ff.ca <= csr_pwdata[3:0];
            REG_RB: cfg_ff.rb <= csr_pwdata[3:0];
            REG_CB: cfg_ff.cb <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_OP: csr_prdata = {29'd0, cfg_ff.op};
         REG_RA: csr_prdata = {28'd0, cfg_ff.ra};
         REG_CA: csr_prdata = {28'd0, cfg_ff.ca};
         REG_RB: csr_prdata = {28'd0, cfg_ff.rb};
         REG_CB: csr_prdata = {28'd0, cfg_ff.cb};
         default: csr_prdata = '0;
      endcase
   end
endmodule
